// ----- hw/rtl/smmh_pkg.sv -----
// ---------------------------------------------------------------------------
// smmh_pkg
// Shared types and constants for the spectrum min/max/mean hold block.
// ---------------------------------------------------------------------------
package smmh_pkg;

    localparam int NUM_BINS_DEF   = 256;
    localparam int NUM_BLOCKS_DEF = 5;

    localparam int AMP_W   = 8;
    localparam int MEAN_W  = 16;
    localparam int CNT_W   = 16;
    localparam int BLK_W   = 3;
    localparam int BIN_W   = 8;
    localparam int WORD_W  = 2 * AMP_W + MEAN_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // one quotient bit per divider step
    localparam int DIV_STEPS = MEAN_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SETUP,
        S_DIV,
        S_WRITE
    } t_state;

endpackage

// ----- hw/rtl/spectrum_min_max_mean_hold.sv -----
// ---------------------------------------------------------------------------
// spectrum_min_max_mean_hold
// Per-bin minimum, maximum and running mean of spectrum amplitudes.
// ---------------------------------------------------------------------------
// A sample whose block has a nonzero frame count keeps the block busy
// through the idle/accept, statistics memory read, setup, divider and
// write-back states in that order; the shared restoring divider yields one
// quotient bit per cycle, and the result is registered at write-back. A
// sample in the first frame after reset or clear skips the divider. Clear
// requests and samples with an out-of-range block or bin are consumed in the
// idle state and give no result. The result sits in an output register, so
// the next sample is taken while an earlier result waits; the write-back
// state waits only if that register is still full.
// The mean is unsigned 8.8 fixed point.
// ---------------------------------------------------------------------------
module spectrum_min_max_mean_hold
    import smmh_pkg::*;
#(
    parameter int NUM_BINS   = NUM_BINS_DEF,
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [BLK_W-1:0]  i_block_index,
    input  logic [BIN_W-1:0]  i_bin_index,
    input  logic [AMP_W-1:0]  i_amplitude,
    input  logic              i_last_bin,

    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BLK_W-1:0]  o_out_block,
    output logic [BIN_W-1:0]  o_out_bin,
    output logic [AMP_W-1:0]  o_cur_amplitude,
    output logic [AMP_W-1:0]  o_min_amplitude,
    output logic [AMP_W-1:0]  o_max_amplitude,
    output logic [MEAN_W-1:0] o_mean_amplitude,
    output logic              o_frame_end
);

    localparam int DEPTH = NUM_BLOCKS * NUM_BINS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BKW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    t_state r_state, n_state;

    // statistics memory: {min, max, mean}
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    logic [NUM_BLOCKS-1:0][CNT_W-1:0] r_count;

    logic [AW-1:0]     r_addr;
    logic [BLK_W-1:0]  r_blk;
    logic [BIN_W-1:0]  r_bin;
    logic [AMP_W-1:0]  r_amp;
    logic              r_last;

    logic [AMP_W-1:0]  r_min;
    logic [AMP_W-1:0]  r_max;
    logic [MEAN_W-1:0] r_mean;
    logic              r_neg;
    logic [MEAN_W-1:0] r_quo;
    logic [MEAN_W:0]   r_rem;
    logic [MEAN_W:0]   r_div;
    logic [STEP_W-1:0] r_step;

    logic              r_out_valid;
    logic [BLK_W-1:0]  r_o_block;
    logic [BIN_W-1:0]  r_o_bin;
    logic [AMP_W-1:0]  r_o_cur;
    logic [AMP_W-1:0]  r_o_min;
    logic [AMP_W-1:0]  r_o_max;
    logic [MEAN_W-1:0] r_o_mean;
    logic              r_o_end;

    logic              in_xfer;
    logic              in_range;
    logic              is_clear;
    logic              out_free;
    logic              do_load;
    logic              do_div;
    logic              do_done;
    logic [BKW-1:0]    blk_idx;
    logic [CNT_W-1:0]  cnt_cur;
    logic              cnt_zero;
    logic              div_last;

    logic [AMP_W-1:0]  rd_min;
    logic [AMP_W-1:0]  rd_max;
    logic [MEAN_W-1:0] rd_mean;
    logic [MEAN_W:0]   diff;
    logic [MEAN_W:0]   diff_neg;
    logic [MEAN_W:0]   shift_rem;
    logic [MEAN_W+1:0] trial;
    logic              fit;
    logic [MEAN_W-1:0] n_mean;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign is_clear = (i_req_type == REQ_CLEAR);
    assign in_range = (4'(i_block_index) < 4'(NUM_BLOCKS))
                   && (11'(i_bin_index) < 11'(NUM_BINS));
    assign out_free = !r_out_valid || i_out_ready;

    assign blk_idx  = BKW'(r_blk);
    assign cnt_cur  = r_count[blk_idx];
    assign cnt_zero = (cnt_cur == '0);
    assign div_last = (r_step == STEP_W'(DIV_STEPS - 1));

    assign {rd_min, rd_max, rd_mean} = r_rd_data;

    // signed distance from the stored mean to the new sample, 8.8
    assign diff     = {1'b0, r_amp, 8'h00} - {1'b0, rd_mean};
    assign diff_neg = -diff;

    // restoring divider step
    assign shift_rem = {r_rem[MEAN_W-1:0], r_quo[MEAN_W-1]};
    assign trial     = {1'b0, shift_rem} - {1'b0, r_div};
    assign fit       = !trial[MEAN_W+1];

    assign n_mean = r_neg ? (r_mean - r_quo) : (r_mean + r_quo);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && !is_clear && in_range) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_SETUP;
            S_SETUP: n_state = cnt_zero ? S_WRITE : S_DIV;
            S_DIV: begin
                if (div_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        do_load    = 1'b0;
        do_div     = 1'b0;
        do_done    = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_READ:  ;
            S_SETUP: do_load = 1'b1;
            S_DIV:   do_div = 1'b1;
            S_WRITE: do_done = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[r_addr];
        end
        if (do_done) begin
            r_mem[r_addr] <= {r_min, r_max, n_mean};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_xfer && is_clear) begin
            r_count <= '0;
        end else if (do_done && r_last && (cnt_cur != COUNT_MAX)) begin
            r_count[blk_idx] <= cnt_cur + CNT_W'(1);
        end
    end

    // sample capture, setup and divider
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_addr <= AW'(32'(i_block_index) * 32'(NUM_BINS) + 32'(i_bin_index));
            r_blk  <= i_block_index;
            r_bin  <= i_bin_index;
            r_amp  <= i_amplitude;
            r_last <= i_last_bin;
        end
        if (do_load) begin
            r_rem  <= '0;
            r_step <= '0;
            r_div  <= {1'b0, cnt_cur} + (MEAN_W+1)'(1);
            if (cnt_zero) begin
                r_min  <= r_amp;
                r_max  <= r_amp;
                r_mean <= {r_amp, 8'h00};
                r_neg  <= 1'b0;
                r_quo  <= '0;
            end else begin
                r_min  <= (r_amp < rd_min) ? r_amp : rd_min;
                r_max  <= (r_amp > rd_max) ? r_amp : rd_max;
                r_mean <= rd_mean;
                r_neg  <= diff[MEAN_W];
                r_quo  <= diff[MEAN_W] ? diff_neg[MEAN_W-1:0] : diff[MEAN_W-1:0];
            end
        end else if (do_div) begin
            r_rem  <= fit ? trial[MEAN_W:0] : shift_rem;
            r_quo  <= {r_quo[MEAN_W-2:0], fit};
            r_step <= r_step + STEP_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_done) begin
            r_o_block <= r_blk;
            r_o_bin   <= r_bin;
            r_o_cur   <= r_amp;
            r_o_min   <= r_min;
            r_o_max   <= r_max;
            r_o_mean  <= n_mean;
            r_o_end   <= r_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_block      = r_o_block;
    assign o_out_bin        = r_o_bin;
    assign o_cur_amplitude  = r_o_cur;
    assign o_min_amplitude  = r_o_min;
    assign o_max_amplitude  = r_o_max;
    assign o_mean_amplitude = r_o_mean;
    assign o_frame_end      = r_o_end;

`ifndef SYNTHESIS
    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_div_runs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !div_last) |=> (r_state == S_DIV))
        else $error("divider left before its last step");

    a_result_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_WRITE))
        else $error("result loaded outside write-back");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past((in_xfer && is_clear) || (do_done && r_last)))
        else $error("frame count changed without clear or frame end");
`endif

endmodule

// ----- dv/spectrum_stats_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// spectrum_stats_checker
// Watches both channels of the min/max/mean hold block, keeps its own copy of
// the per-bin statistics and frame counts, and compares every result
// transfer against the oldest predicted statistics.
// ---------------------------------------------------------------------------
module spectrum_stats_checker
    import smmh_pkg::*;
#(
    parameter int NUM_BINS   = NUM_BINS_DEF,
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_req_type,
    input  logic [BLK_W-1:0]  i_block_index,
    input  logic [BIN_W-1:0]  i_bin_index,
    input  logic [AMP_W-1:0]  i_amplitude,
    input  logic              i_last_bin,

    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [BLK_W-1:0]  i_out_block,
    input  logic [BIN_W-1:0]  i_out_bin,
    input  logic [AMP_W-1:0]  i_cur_amplitude,
    input  logic [AMP_W-1:0]  i_min_amplitude,
    input  logic [AMP_W-1:0]  i_max_amplitude,
    input  logic [MEAN_W-1:0] i_mean_amplitude,
    input  logic              i_frame_end,

    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [BLK_W-1:0]  blk;
        logic [BIN_W-1:0]  bin;
        logic [AMP_W-1:0]  cur;
        logic [AMP_W-1:0]  lo;
        logic [AMP_W-1:0]  hi;
        logic [MEAN_W-1:0] mean;
        logic              frame_end;
    } t_bin_stats;

    logic [AMP_W-1:0]  min_hold  [NUM_BLOCKS*NUM_BINS];
    logic [AMP_W-1:0]  max_hold  [NUM_BLOCKS*NUM_BINS];
    logic [MEAN_W-1:0] mean_hold [NUM_BLOCKS*NUM_BINS];
    logic [CNT_W-1:0]  frames_done [NUM_BLOCKS];
    t_bin_stats        expected_stats_q [$];

    // mean moves toward the new sample by diff / (frames + 1), truncated toward zero
    function automatic logic [MEAN_W-1:0] next_mean(logic [MEAN_W-1:0] mean,
                                                    logic [AMP_W-1:0] amp,
                                                    logic [CNT_W-1:0] frames);
        int target;
        int diff;
        int divisor;
        int sum;
        target  = int'({amp, 8'h00});
        diff    = target - int'(mean);
        divisor = int'(frames) + 1;
        sum     = int'(mean) + diff / divisor;
        return MEAN_W'(sum);
    endfunction

    function automatic t_bin_stats update_bin_stats(logic [BLK_W-1:0] blk,
                                                    logic [BIN_W-1:0] bin,
                                                    logic [AMP_W-1:0] amp,
                                                    logic last);
        int         addr;
        t_bin_stats stats;
        addr = int'(blk) * NUM_BINS + int'(bin);
        if (frames_done[blk] == '0) begin
            min_hold[addr]  = amp;
            max_hold[addr]  = amp;
            mean_hold[addr] = {amp, 8'h00};
        end else begin
            if (amp < min_hold[addr]) min_hold[addr] = amp;
            if (amp > max_hold[addr]) max_hold[addr] = amp;
            mean_hold[addr] = next_mean(mean_hold[addr], amp, frames_done[blk]);
        end
        if (last && frames_done[blk] != COUNT_MAX) begin
            frames_done[blk] = frames_done[blk] + 1'b1;
        end
        stats.blk       = blk;
        stats.bin       = bin;
        stats.cur       = amp;
        stats.lo        = min_hold[addr];
        stats.hi        = max_hold[addr];
        stats.mean      = mean_hold[addr];
        stats.frame_end = last;
        return stats;
    endfunction

    // four-state compare so an unknown result bit counts as a mismatch
    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_bin_stats want;
        if (!i_rst_n) begin
            foreach (frames_done[b]) frames_done[b] = '0;
            expected_stats_q.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_stats_q.size() == 0) begin
                    $error("result transfer with no statistics pending: block %0d bin %0d",
                           i_out_block, i_out_bin);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_stats_q.pop_front();
                    compare_field("out_block", want.blk, i_out_block);
                    compare_field("out_bin", want.bin, i_out_bin);
                    compare_field("cur_amplitude", want.cur, i_cur_amplitude);
                    compare_field("min_amplitude", want.lo, i_min_amplitude);
                    compare_field("max_amplitude", want.hi, i_max_amplitude);
                    compare_field("mean_amplitude", want.mean, i_mean_amplitude);
                    compare_field("frame_end", want.frame_end, i_frame_end);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_req_type == REQ_CLEAR) begin
                    foreach (frames_done[b]) frames_done[b] = '0;
                end else if (int'(i_block_index) < NUM_BLOCKS
                             && int'(i_bin_index) < NUM_BINS) begin
                    expected_stats_q.push_back(update_bin_stats(i_block_index, i_bin_index,
                                                                i_amplitude, i_last_bin));
                end
            end
            o_pending = expected_stats_q.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives spectrum frames, stray samples and clear requests into the min/max/
// mean hold block with random gaps on both channels; the checker module
// judges every result.
// ---------------------------------------------------------------------------
module testbench;
    import smmh_pkg::*;

    localparam int NUM_BINS        = NUM_BINS_DEF;
    localparam int NUM_BLOCKS      = NUM_BLOCKS_DEF;
    localparam int RANDOM_SAMPLES  = 1900;
    localparam int DRAIN_CYCLES    = 40;

    logic              clk;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic              req_type       = REQ_SAMPLE;
    logic [BLK_W-1:0]  block_index    = '0;
    logic [BIN_W-1:0]  bin_index      = '0;
    logic [AMP_W-1:0]  amplitude      = '0;
    logic              last_bin       = 1'b0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic [BLK_W-1:0]  out_block;
    logic [BIN_W-1:0]  out_bin;
    logic [AMP_W-1:0]  cur_amplitude;
    logic [AMP_W-1:0]  min_amplitude;
    logic [AMP_W-1:0]  max_amplitude;
    logic [MEAN_W-1:0] mean_amplitude;
    logic              frame_end;
    int                fail_count;
    int                pending;

    // sender-side view of which entries hold data, so no unwritten entry is read
    int                frames_sent     [NUM_BLOCKS];
    bit                bin_written     [NUM_BLOCKS][NUM_BINS];
    logic [BIN_W-1:0]  any_written_bin [NUM_BLOCKS];
    logic [BIN_W-1:0]  layout_base     [NUM_BLOCKS];
    int                layout_len      [NUM_BLOCKS];
    int                samples_sent    = 0;
    bit                valid_high      = 1'b0;

    spectrum_min_max_mean_hold #(
        .NUM_BINS   (NUM_BINS),
        .NUM_BLOCKS (NUM_BLOCKS)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_block_index    (block_index),
        .i_bin_index      (bin_index),
        .i_amplitude      (amplitude),
        .i_last_bin       (last_bin),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_out_block      (out_block),
        .o_out_bin        (out_bin),
        .o_cur_amplitude  (cur_amplitude),
        .o_min_amplitude  (min_amplitude),
        .o_max_amplitude  (max_amplitude),
        .o_mean_amplitude (mean_amplitude),
        .o_frame_end      (frame_end)
    );

    spectrum_stats_checker #(
        .NUM_BINS   (NUM_BINS),
        .NUM_BLOCKS (NUM_BLOCKS)
    ) stats_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_block_index    (block_index),
        .i_bin_index      (bin_index),
        .i_amplitude      (amplitude),
        .i_last_bin       (last_bin),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_block      (out_block),
        .i_out_bin        (out_bin),
        .i_cur_amplitude  (cur_amplitude),
        .i_min_amplitude  (min_amplitude),
        .i_max_amplitude  (max_amplitude),
        .i_mean_amplitude (mean_amplitude),
        .i_frame_end      (frame_end),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #(30_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 19);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [AMP_W-1:0] pick_amp();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return AMP_W'($urandom);
    endfunction

    // once a block has a frame counted, only bins that already hold data may be sampled
    function automatic logic [BIN_W-1:0] legal_bin(logic [BLK_W-1:0] blk, logic [BIN_W-1:0] bin);
        if (frames_sent[blk] == 0 || bin_written[blk][bin]) return bin;
        return any_written_bin[blk];
    endfunction

    initial begin : drive_out_ready
        int run;
        int gap;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 8);
            gap = pick_gap();
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    task automatic send_item(logic req, logic [BLK_W-1:0] blk, logic [BIN_W-1:0] bin,
                             logic [AMP_W-1:0] amp, logic last);
        in_valid    <= 1'b1;
        req_type    <= req;
        block_index <= blk;
        bin_index   <= bin;
        amplitude   <= amp;
        last_bin    <= last;
        valid_high  = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (req == REQ_CLEAR) begin
            foreach (frames_sent[b]) frames_sent[b] = 0;
        end else if (int'(blk) < NUM_BLOCKS && int'(bin) < NUM_BINS) begin
            bin_written[blk][bin] = 1'b1;
            any_written_bin[blk]  = bin;
            samples_sent++;
            if (last) frames_sent[blk]++;
        end
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            if (valid_high) begin
                in_valid   <= 1'b0;
                valid_high = 1'b0;
            end
            // payload wanders while nothing is offered
            req_type    <= 1'($urandom);
            block_index <= BLK_W'($urandom);
            bin_index   <= BIN_W'($urandom);
            amplitude   <= AMP_W'($urandom);
            last_bin    <= 1'($urandom);
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        if (valid_high) begin
            in_valid   <= 1'b0;
            valid_high = 1'b0;
        end
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // a frame reuses the block's bin layout until the counter returns to zero
    task automatic send_frame(logic [BLK_W-1:0] blk, bit steady, bit broken);
        int  n;
        bit  cut_last;
        logic [BIN_W-1:0] bin;
        if (frames_sent[blk] == 0) begin
            layout_base[blk] = BIN_W'($urandom_range(0, NUM_BINS - 1));
            layout_len[blk]  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                           : $urandom_range(1, 6);
        end
        n = layout_len[blk];
        cut_last = 1'b0;
        if (broken) begin
            n = $urandom_range(1, n);
            cut_last = 1'($urandom_range(0, 1));
        end
        for (int k = 0; k < n; k++) begin
            bin = BIN_W'((int'(layout_base[blk]) + k) % NUM_BINS);
            send_item(REQ_SAMPLE, blk, legal_bin(blk, bin), pick_amp(),
                      (k == n - 1) && !cut_last);
            if (!steady) pause_sender(pick_gap());
        end
    endtask

    initial begin : make_stimulus
        int  choice;
        logic [BLK_W-1:0] blk;
        foreach (frames_sent[b]) begin
            frames_sent[b]     = 0;
            any_written_bin[b] = '0;
            layout_base[b]     = '0;
            layout_len[b]      = 1;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // blocks beyond the last one are dropped without a result
        send_item(REQ_SAMPLE, 3'd5, 8'h00, 8'h00, 1'b0);
        send_item(REQ_SAMPLE, 3'd6, 8'hFF, 8'hFF, 1'b1);
        send_item(REQ_SAMPLE, 3'd7, 8'h80, 8'h01, 1'b1);
        // first frame loads all three stores directly
        send_item(REQ_SAMPLE, 3'd0, 8'h00, 8'h00, 1'b0);
        send_item(REQ_SAMPLE, 3'd0, 8'hFF, 8'hFF, 1'b0);
        send_item(REQ_SAMPLE, 3'd0, 8'h01, 8'hAA, 1'b1);
        // full swings up and down against the running mean
        send_item(REQ_SAMPLE, 3'd0, 8'h00, 8'hFF, 1'b0);
        send_item(REQ_SAMPLE, 3'd0, 8'hFF, 8'h00, 1'b0);
        send_item(REQ_SAMPLE, 3'd0, 8'h01, 8'h55, 1'b1);
        send_item(REQ_SAMPLE, 3'd0, 8'h00, 8'h00, 1'b0);
        send_item(REQ_SAMPLE, 3'd0, 8'hFF, 8'hFF, 1'b0);
        send_item(REQ_SAMPLE, 3'd0, 8'h01, 8'hAA, 1'b1);
        send_item(REQ_SAMPLE, 3'd4, 8'h80, 8'h80, 1'b0);
        send_item(REQ_SAMPLE, 3'd4, 8'h7F, 8'h7F, 1'b1);
        send_item(REQ_SAMPLE, 3'd1, 8'h55, 8'h01, 1'b1);
        send_item(REQ_SAMPLE, 3'd2, 8'hAA, 8'hFE, 1'b1);
        send_item(REQ_SAMPLE, 3'd3, 8'h0F, 8'hF0, 1'b1);
        // clear with every other field set; old contents must be overwritten
        send_item(REQ_CLEAR, 3'd7, 8'hFF, 8'hFF, 1'b1);
        send_item(REQ_SAMPLE, 3'd0, 8'h00, 8'h33, 1'b1);
        send_item(REQ_SAMPLE, 3'd0, 8'h00, 8'hCC, 1'b1);
        wait_results_drained();

        samples_sent = 0;
        while (samples_sent < RANDOM_SAMPLES) begin
            choice = $urandom_range(0, 99);
            blk    = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
            if (choice < 80) begin
                send_frame(blk, $urandom_range(0, 7) == 0, 1'b0);
            end else if (choice < 90) begin
                send_frame(blk, 1'b0, 1'b1);
            end else if (choice < 95) begin
                if ($urandom_range(0, 1)) begin
                    send_item(REQ_SAMPLE, BLK_W'($urandom_range(NUM_BLOCKS, 7)),
                              BIN_W'($urandom), AMP_W'($urandom), 1'($urandom));
                end else begin
                    send_item(REQ_SAMPLE, blk, legal_bin(blk, BIN_W'($urandom)),
                              pick_amp(), 1'($urandom));
                end
            end else if (choice < 98) begin
                send_item(REQ_CLEAR, BLK_W'($urandom), BIN_W'($urandom),
                          AMP_W'($urandom), 1'($urandom));
            end else begin
                wait_results_drained();
            end
            pause_sender(pick_gap());
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/smmh_pkg.sv
hw/rtl/spectrum_min_max_mean_hold.sv
dv/spectrum_stats_checker.sv
dv/testbench.sv
